// File: design/assert_macros.svh
// Assertion macros used by the checker file.
// Each expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, ignored while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/pfb_pkg.sv
`timescale 1ns / 1ps

package pfb_pkg;

  // Command codes carried in a drawing transaction.
  typedef enum logic [2:0] {
    CMD_PIXEL      = 3'd0,
    CMD_READ_PIXEL = 3'd1,
    CMD_HLINE      = 3'd2,
    CMD_VLINE      = 3'd3,
    CMD_RECT       = 3'd4,
    CMD_WRITE_BYTE = 3'd5,
    CMD_READ_BYTE  = 3'd6,
    CMD_FILL       = 3'd7
  } cmd_t;

  // Colour codes; code three behaves as off.
  localparam logic [1:0] COL_OFF    = 2'd0;
  localparam logic [1:0] COL_ON     = 2'd1;
  localparam logic [1:0] COL_TOGGLE = 2'd2;

  localparam logic [7:0] BYTE_ALL_ON  = 8'hFF;
  localparam logic [7:0] BYTE_ALL_OFF = 8'h00;

  // Pixels in one vertical byte, less one.
  localparam logic [7:0] BYTE_SPAN_M1 = 8'd7;

endpackage

// File: design/pfb_if.sv
`timescale 1ns / 1ps

// Drawing command channel.
interface pfb_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] x_pos;
  logic [7:0] y_pos;
  logic [7:0] x_end;
  logic [7:0] y_end;
  logic [1:0] color;
  logic [7:0] data_byte;

  modport source (
    output valid, command, x_pos, y_pos, x_end, y_end, color, data_byte,
    input  ready
  );
  modport sink (
    input  valid, command, x_pos, y_pos, x_end, y_end, color, data_byte,
    output ready
  );
endinterface

// Read result channel.
interface pfb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// File: design/pfb_frame_mem.sv
`timescale 1ns / 1ps

// Single-port-read, single-port-write frame store with registered read data.
module pfb_frame_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data
);

  logic [7:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/page_framebuffer_draw_engine_top.sv
`timescale 1ns / 1ps

// Channel   Modport  Direction  Payload
// cmd       sink     in         command, x_pos, y_pos, x_end, y_end, color, data_byte
// rsp       source   out        read_data (read pixel and read byte only)
//
// Every drawn pixel goes through one read-modify-write of the frame store on its single
// read and write port; read commands only read, and off-screen pixels touch no memory.
// A line runs along its pixels, a rectangle along its four sides, and write byte and
// read byte along the eight pixels of one vertical byte; reads then load the result register.
// Fill and the clearing pass after reset sweep all SCREEN_WIDTH * PAGE_COUNT bytes
// (1024 by default), one byte a cycle, with cmd.ready low.
// A result waits in an output register, so the next command is taken while it is held;
// a later read that finishes before rsp takes the earlier result waits for it.

module page_framebuffer_draw_engine_top #(
  parameter int SCREEN_WIDTH = 128,
  parameter int PAGE_COUNT   = 8
) (
  input logic         clk,
  input logic         rst,
  pfb_cmd_if.sink     cmd,
  pfb_rsp_if.source   rsp
);

  localparam int DEPTH  = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_WR,
    S_DONE
  } state_t;

  // Start point, direction and length of one straight run of pixels.
  typedef struct packed {
    logic [7:0] px;
    logic [7:0] py;
    logic       horiz;
    logic [7:0] len_m1;
  } seg_t;

  state_t            state;
  pfb_pkg::cmd_t     cmd_q;
  logic [1:0]        color_q;
  logic [7:0]        data_q;
  logic [7:0]        x0;
  logic [7:0]        y0;
  logic [7:0]        xe;
  logic [7:0]        ye;
  logic [1:0]        seg;
  logic              horiz;
  logic [7:0]        px;
  logic [7:0]        py;
  logic [7:0]        remain;
  logic [2:0]        bit_j;
  logic [7:0]        acc;
  logic [ADDR_W-1:0] clr_addr;
  logic [7:0]        fill_byte;
  logic              out_valid;
  logic [7:0]        out_data;

  logic [ADDR_W-1:0] pix_addr;
  logic              pix_hit;
  logic [7:0]        mask;
  logic [1:0]        pix_col;
  logic [7:0]        rd_data;
  logic [7:0]        mod_byte;
  logic              rd_en;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              is_read;
  logic              last_seg;
  seg_t              first_seg;
  seg_t              next_seg;

  // Works out where segment s of a command starts and how far it runs.
  function automatic seg_t seg_setup(pfb_pkg::cmd_t c, logic [1:0] s, logic [7:0] xa,
                                     logic [7:0] ya, logic [7:0] xb, logic [7:0] yb);
    seg_t r;
    r.px     = xa;
    r.py     = ya;
    r.horiz  = 1'b0;
    r.len_m1 = 8'd0;
    unique case (c)
      pfb_pkg::CMD_HLINE: begin
        r.horiz  = 1'b1;
        r.len_m1 = xb - xa;
      end
      pfb_pkg::CMD_VLINE: begin
        r.len_m1 = yb - ya;
      end
      pfb_pkg::CMD_RECT: begin
        unique case (s)
          2'd0: begin
            r.horiz  = 1'b1;
            r.len_m1 = xb - xa;
          end
          2'd1: begin
            r.py     = yb;
            r.horiz  = 1'b1;
            r.len_m1 = xb - xa;
          end
          2'd2: begin
            r.len_m1 = yb - ya;
          end
          default: begin
            r.px     = xb;
            r.len_m1 = yb - ya;
          end
        endcase
      end
      pfb_pkg::CMD_WRITE_BYTE, pfb_pkg::CMD_READ_BYTE: begin
        r.len_m1 = pfb_pkg::BYTE_SPAN_M1;
      end
      pfb_pkg::CMD_PIXEL, pfb_pkg::CMD_READ_PIXEL, pfb_pkg::CMD_FILL: begin
        r.len_m1 = 8'd0;
      end
    endcase
    return r;
  endfunction

  assign first_seg = seg_setup(pfb_pkg::cmd_t'(cmd.command), 2'd0, cmd.x_pos, cmd.y_pos,
                               cmd.x_end, cmd.y_end);
  assign next_seg  = seg_setup(cmd_q, seg + 2'd1, x0, y0, xe, ye);

  // Byte address and visibility of the current pixel.
  assign pix_hit  = (9'(px) < 9'(SCREEN_WIDTH)) && (6'(py[7:3]) < 6'(PAGE_COUNT));
  assign pix_addr = ADDR_W'(px) + ADDR_W'(32'(py[7:3]) * SCREEN_WIDTH);
  assign mask     = 8'b1 << py[2:0];

  assign is_read  = (cmd_q == pfb_pkg::CMD_READ_PIXEL) || (cmd_q == pfb_pkg::CMD_READ_BYTE);
  assign last_seg = (cmd_q != pfb_pkg::CMD_RECT) || (seg == 2'd3);

  // Colour of the current pixel: byte writes take it from the data bits.
  assign pix_col = (cmd_q == pfb_pkg::CMD_WRITE_BYTE)
                 ? (data_q[bit_j] ? pfb_pkg::COL_ON : pfb_pkg::COL_OFF)
                 : color_q;

  // Modify step of the read-modify-write.
  always_comb begin
    if (pix_col == pfb_pkg::COL_ON) begin
      mod_byte = rd_data | mask;
    end else if (pix_col == pfb_pkg::COL_TOGGLE) begin
      mod_byte = rd_data ^ mask;
    end else begin
      mod_byte = rd_data & ~mask;
    end
  end

  // Memory port control: the sweep writes one byte a cycle, pixels read, then write unless the command is a read.
  always_comb begin
    rd_en   = (state == S_RD) && pix_hit;
    wr_en   = 1'b0;
    wr_addr = pix_addr;
    wr_data = mod_byte;
    if (state == S_CLR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = fill_byte;
    end else if (state == S_WR) begin
      wr_en = pix_hit && !is_read;
    end
  end

  pfb_frame_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (pix_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign cmd.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;

  // Sequencer, pixel stepper and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      fill_byte <= pfb_pkg::BYTE_ALL_OFF;
      out_valid <= 1'b0;
    end else begin
      // A taken result is dropped here unless a new one is loaded below.
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            cmd_q   <= pfb_pkg::cmd_t'(cmd.command);
            color_q <= cmd.color;
            data_q  <= cmd.data_byte;
            x0      <= cmd.x_pos;
            y0      <= cmd.y_pos;
            xe      <= cmd.x_end;
            ye      <= cmd.y_end;
            seg     <= 2'd0;
            px      <= first_seg.px;
            py      <= first_seg.py;
            horiz   <= first_seg.horiz;
            remain  <= first_seg.len_m1;
            bit_j   <= 3'd0;
            acc     <= 8'd0;
            if (pfb_pkg::cmd_t'(cmd.command) == pfb_pkg::CMD_FILL) begin
              clr_addr  <= '0;
              fill_byte <= (cmd.color == pfb_pkg::COL_ON) ? pfb_pkg::BYTE_ALL_ON
                                                          : pfb_pkg::BYTE_ALL_OFF;
              state     <= S_CLR;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (is_read) begin
            acc <= acc | (8'(pix_hit && rd_data[py[2:0]]) << bit_j);
          end
          if (remain != 8'd0) begin
            remain <= remain - 8'd1;
            bit_j  <= bit_j + 3'd1;
            if (horiz) begin
              px <= px + 8'd1;
            end else begin
              py <= py + 8'd1;
            end
            state <= S_RD;
          end else if (!last_seg) begin
            seg    <= seg + 2'd1;
            px     <= next_seg.px;
            py     <= next_seg.py;
            horiz  <= next_seg.horiz;
            remain <= next_seg.len_m1;
            state  <= S_RD;
          end else if (is_read) begin
            state <= S_DONE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_data  <= acc;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/pfb_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks on the drawing engine.
module pfb_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_read_data
);

  // A held result keeps its value until it is taken.
  `ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data), "result changed while stalled")

  // The engine works on one command at a time, so ready drops after every transaction.
  `ASSERT_CLK(a_one_at_a_time, cmd_valid && cmd_ready |=> !cmd_ready, "ready stayed high after a transaction")

  // No result appears in the cycle after a transaction, since a result is loaded only from the done state.
  `ASSERT_CLK(a_no_early_result, cmd_valid && cmd_ready |=> !$rose(rsp_valid), "result appeared too early")

  // Reset starts the clearing pass with nothing to deliver.
  `ASSERT_ALWAYS(a_reset_quiet, rst |=> !cmd_ready && !rsp_valid, "engine active right after reset")

endmodule

bind page_framebuffer_draw_engine_top pfb_checker u_pfb_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_read_data (rsp.read_data)
);
